// File: rtl/sfr_pkg.sv
// shared types and constants for the schlick fresnel reflectance block
// no dependencies; imported by every module under rtl
package sfr_pkg;

    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 16;
    localparam int MUL_STEPS  = 5;
    localparam int NCELL      = DIV_STEPS + SQRT_STEPS + MUL_STEPS;

    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [15:0] HALF_Q15 = 16'h4000;

    typedef struct packed {
        logic signed [15:0] eye_x;
        logic signed [15:0] eye_y;
        logic signed [15:0] eye_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [14:0]        index_from;
        logic [14:0]        index_to;
    } item_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } result_t;

    // per-stage side data that travels with the cell chains
    typedef struct packed {
        logic [15:0] c;
        logic        gt;
        logic        tir;
        logic        dz;
        logic        sz;
        logic [15:0] r0;
        logic [15:0] x;
    } side_t;

endpackage

// File: rtl/sfr_div_cell.sv
// one restoring division step: one quotient bit per cell
// depends on sfr_pkg
module sfr_div_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] rem_in,
    input  logic [31:0] den_in,
    input  logic [30:0] low_in,
    input  logic [30:0] quo_in,
    output logic [31:0] rem_reg,
    output logic [31:0] den_reg,
    output logic [30:0] low_reg,
    output logic [30:0] quo_reg
);
    import sfr_pkg::*;

    logic [32:0] trial;
    logic        take;
    logic [31:0] rem_next;

    always_comb
    begin
        trial    = {rem_in, low_in[30]};
        take     = (trial >= {1'b0, den_in});
        rem_next = take ? 32'(trial - {1'b0, den_in}) : trial[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            low_reg <= {low_in[29:0], 1'b0};
            quo_reg <= {quo_in[29:0], take};
        end
    end

endmodule

// File: rtl/sfr_sqrt_cell.sv
// one digit-by-digit square root step: one root bit per cell
// depends on sfr_pkg
module sfr_sqrt_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [17:0] rem_in,
    input  logic [15:0] root_in,
    input  logic [31:0] low_in,
    output logic [17:0] rem_reg,
    output logic [15:0] root_reg,
    output logic [31:0] low_reg
);
    import sfr_pkg::*;

    logic [19:0] t;
    logic [17:0] trial;
    logic        take;

    always_comb
    begin
        t     = {rem_in, low_in[31:30]};
        trial = {root_in, 2'b01};
        take  = (t >= {2'b00, trial});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= take ? 18'(t - {2'b00, trial}) : t[17:0];
            root_reg <= {root_in[14:0], take};
            low_reg  <= {low_in[29:0], 2'b00};
        end
    end

endmodule

// File: rtl/sfr_mul_cell.sv
// q1.15 multiply with round half up, registered
// depends on sfr_pkg
module sfr_mul_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] p_reg
);
    import sfr_pkg::*;

    logic [31:0] prod;

    always_comb
    begin
        prod = 32'(a) * 32'(b) + {16'b0, HALF_Q15};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= prod[30:15];
        end
    end

endmodule

// File: rtl/schlick_fresnel_reflectance.sv
// schlick fresnel reflectance: dot product, tir check, divider, sqrt and pow5 cell chains
// depends on sfr_pkg, sfr_div_cell, sfr_sqrt_cell, sfr_mul_cell
//
//  channel  | payload  | handshake
//  ---------+----------+----------------------------
//  item     | item_t   | item_valid / item_stall
//  result   | result_t | result_valid / result_stall
//
// one beat in and one beat out per cycle while no result beat is stalled
// 58 register stages: 5 front stages, 31 divider cells, 16 sqrt cells, 5 multiply cells
// and the result register
// whole pipeline holds while a result beat is stalled; otherwise a beat enters every cycle
// reset clears only the valid bits, no clearing pass
module schlick_fresnel_reflectance (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sfr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sfr_pkg::result_t result
);
    import sfr_pkg::*;

    logic en;

    // front stages a..e
    logic               vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg, vld_e_reg;
    logic signed [31:0] px_a_reg, py_a_reg, pz_a_reg;
    logic [29:0]        n1sq_a_reg, n2sq_a_reg;
    logic [14:0]        d_a_reg;
    logic [15:0]        s_a_reg;
    logic               gt_a_reg;

    logic [15:0]        c_b_reg;
    logic [31:0]        ssq_b_reg;
    logic [29:0]        dsq_b_reg, n1sq_b_reg, n2sq_b_reg;
    logic               gt_b_reg;

    logic [30:0]        csq_c_reg;
    logic [45:0]        rnum_c_reg;
    logic [31:0]        ssq_c_reg;
    logic [29:0]        n1sq_c_reg, n2sq_c_reg;
    logic [15:0]        c_c_reg;
    logic               gt_c_reg;

    logic [30:0]        om_d_reg;
    logic [45:0]        rnum_d_reg;
    logic [31:0]        ssq_d_reg;
    logic [29:0]        n1sq_d_reg, n2sq_d_reg;
    logic [15:0]        c_d_reg;
    logic               gt_d_reg;

    logic [60:0]        num_e_reg;
    logic [45:0]        rnum_e_reg;
    logic [31:0]        ssq_e_reg;
    logic [29:0]        n2sq_e_reg;
    logic [15:0]        c_e_reg;
    logic               gt_e_reg;

    logic signed [33:0] dot_sum;
    logic [28:0]        dot_clamp;
    logic [29:0]        dot_round;

    // cell chain side data
    logic [NCELL-1:0]   vld_reg;
    side_t              side_reg [NCELL];
    side_t              side_next [NCELL];
    side_t              side0;

    logic [31:0] sin_rem [DIV_STEPS+1];
    logic [31:0] sin_den [DIV_STEPS+1];
    logic [30:0] sin_low [DIV_STEPS+1];
    logic [30:0] sin_quo [DIV_STEPS+1];
    logic [31:0] r_rem [DIV_STEPS+1];
    logic [31:0] r_den [DIV_STEPS+1];
    logic [30:0] r_low [DIV_STEPS+1];
    logic [30:0] r_quo [DIV_STEPS+1];

    logic [17:0] sq_rem [SQRT_STEPS+1];
    logic [15:0] sq_root [SQRT_STEPS+1];
    logic [31:0] sq_low [SQRT_STEPS+1];

    logic [15:0] mp [MUL_STEPS+1];
    logic [15:0] mb [MUL_STEPS];

    logic [30:0] sin2;
    logic [15:0] r0_val;
    logic [15:0] cf;
    logic [15:0] x_val;
    logic [16:0] res_sum;

    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    assign en           = !(result_valid_reg && result_stall);
    assign item_stall   = !en;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        dot_sum = 34'(px_a_reg) + 34'(py_a_reg) + 34'(pz_a_reg);
        if (dot_sum < 0)
        begin
            dot_clamp = '0;
        end
        else if (dot_sum > 34'sh1000_0000)
        begin
            dot_clamp = 29'h1000_0000;
        end
        else
        begin
            dot_clamp = dot_sum[28:0];
        end
        dot_round = {1'b0, dot_clamp} + 30'd4096;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_a_reg   <= 32'(item.eye_x) * 32'(item.norm_x);
            py_a_reg   <= 32'(item.eye_y) * 32'(item.norm_y);
            pz_a_reg   <= 32'(item.eye_z) * 32'(item.norm_z);
            n1sq_a_reg <= 30'(item.index_from) * 30'(item.index_from);
            n2sq_a_reg <= 30'(item.index_to) * 30'(item.index_to);
            d_a_reg    <= (item.index_from > item.index_to) ?
                          item.index_from - item.index_to : item.index_to - item.index_from;
            s_a_reg    <= {1'b0, item.index_from} + {1'b0, item.index_to};
            gt_a_reg   <= item.index_from > item.index_to;

            c_b_reg    <= dot_round[28:13];
            ssq_b_reg  <= 32'(s_a_reg) * 32'(s_a_reg);
            dsq_b_reg  <= 30'(d_a_reg) * 30'(d_a_reg);
            n1sq_b_reg <= n1sq_a_reg;
            n2sq_b_reg <= n2sq_a_reg;
            gt_b_reg   <= gt_a_reg;

            csq_c_reg  <= 31'(c_b_reg) * 31'(c_b_reg);
            rnum_c_reg <= {1'b0, dsq_b_reg, 15'b0} + {15'b0, ssq_b_reg[31:1]};
            ssq_c_reg  <= ssq_b_reg;
            n1sq_c_reg <= n1sq_b_reg;
            n2sq_c_reg <= n2sq_b_reg;
            c_c_reg    <= c_b_reg;
            gt_c_reg   <= gt_b_reg;

            om_d_reg   <= ONE_Q30 - csq_c_reg;
            rnum_d_reg <= rnum_c_reg;
            ssq_d_reg  <= ssq_c_reg;
            n1sq_d_reg <= n1sq_c_reg;
            n2sq_d_reg <= n2sq_c_reg;
            c_d_reg    <= c_c_reg;
            gt_d_reg   <= gt_c_reg;

            num_e_reg  <= 61'(n1sq_d_reg) * 61'(om_d_reg);
            rnum_e_reg <= rnum_d_reg;
            ssq_e_reg  <= ssq_d_reg;
            n2sq_e_reg <= n2sq_d_reg;
            c_e_reg    <= c_d_reg;
            gt_e_reg   <= gt_d_reg;
        end
    end

    // lane and side entry
    always_comb
    begin
        side0     = '0;
        side0.c   = c_e_reg;
        side0.gt  = gt_e_reg;
        side0.tir = gt_e_reg && (num_e_reg > {1'b0, n2sq_e_reg, 30'b0});
        side0.dz  = (n2sq_e_reg == '0);
        side0.sz  = (ssq_e_reg == '0);
    end

    assign sin_rem[0] = {2'b00, num_e_reg[60:31]};
    assign sin_den[0] = {2'b00, n2sq_e_reg};
    assign sin_low[0] = num_e_reg[30:0];
    assign sin_quo[0] = '0;
    assign r_rem[0]   = {17'b0, rnum_e_reg[45:31]};
    assign r_den[0]   = ssq_e_reg;
    assign r_low[0]   = rnum_e_reg[30:0];
    assign r_quo[0]   = '0;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        sfr_div_cell u_sin (
            .clk    (clk),
            .en     (en),
            .rem_in (sin_rem[k]),
            .den_in (sin_den[k]),
            .low_in (sin_low[k]),
            .quo_in (sin_quo[k]),
            .rem_reg(sin_rem[k+1]),
            .den_reg(sin_den[k+1]),
            .low_reg(sin_low[k+1]),
            .quo_reg(sin_quo[k+1])
        );
        sfr_div_cell u_r0 (
            .clk    (clk),
            .en     (en),
            .rem_in (r_rem[k]),
            .den_in (r_den[k]),
            .low_in (r_low[k]),
            .quo_in (r_quo[k]),
            .rem_reg(r_rem[k+1]),
            .den_reg(r_den[k+1]),
            .low_reg(r_low[k+1]),
            .quo_reg(r_quo[k+1])
        );
    end

    always_comb
    begin
        sin2 = side_reg[DIV_STEPS-1].dz ? '0 : sin_quo[DIV_STEPS];
        if (side_reg[DIV_STEPS-1].sz)
        begin
            r0_val = '0;
        end
        else if (r_quo[DIV_STEPS] > {15'b0, ONE_Q15})
        begin
            r0_val = ONE_Q15;
        end
        else
        begin
            r0_val = r_quo[DIV_STEPS][15:0];
        end
    end

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_low[0]  = {1'b0, ONE_Q30} - {1'b0, sin2};

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        sfr_sqrt_cell u_sq (
            .clk     (clk),
            .en      (en),
            .rem_in  (sq_rem[j]),
            .root_in (sq_root[j]),
            .low_in  (sq_low[j]),
            .rem_reg (sq_rem[j+1]),
            .root_reg(sq_root[j+1]),
            .low_reg (sq_low[j+1])
        );
    end

    always_comb
    begin
        cf    = side_reg[DIV_STEPS+SQRT_STEPS-1].gt ?
                sq_root[SQRT_STEPS] : side_reg[DIV_STEPS+SQRT_STEPS-1].c;
        x_val = ONE_Q15 - cf;
    end

    assign mp[0] = x_val;

    // x^5 over four cells, then (1 - r0) * x^5
    for (genvar i = 0; i < MUL_STEPS; i++)
    begin : g_mul
        if (i == 0)
        begin : g_first
            assign mb[i] = x_val;
        end
        else if (i < MUL_STEPS - 1)
        begin : g_pow
            assign mb[i] = side_reg[DIV_STEPS+SQRT_STEPS+i-1].x;
        end
        else
        begin : g_term
            assign mb[i] = ONE_Q15 - side_reg[DIV_STEPS+SQRT_STEPS+i-1].r0;
        end
        sfr_mul_cell u_mul (
            .clk  (clk),
            .en   (en),
            .a    (mp[i]),
            .b    (mb[i]),
            .p_reg(mp[i+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < NCELL; k++)
        begin
            side_next[k] = (k == 0) ? side0 : side_reg[(k == 0) ? 0 : k-1];
            if (k == DIV_STEPS)
            begin
                side_next[k].r0 = r0_val;
            end
            if (k == DIV_STEPS + SQRT_STEPS)
            begin
                side_next[k].x = x_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NCELL; k++)
            begin
                side_reg[k] <= side_next[k];
            end
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        res_sum = {1'b0, side_reg[NCELL-1].r0} + {1'b0, mp[MUL_STEPS]};
        if (side_reg[NCELL-1].tir)
        begin
            result_next.reflectance    = ONE_Q15;
            result_next.total_internal = 1'b1;
        end
        else
        begin
            result_next.reflectance    = (res_sum > {1'b0, ONE_Q15}) ? ONE_Q15 : res_sum[15:0];
            result_next.total_internal = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg        <= 1'b0;
            vld_b_reg        <= 1'b0;
            vld_c_reg        <= 1'b0;
            vld_d_reg        <= 1'b0;
            vld_e_reg        <= 1'b0;
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg        <= item_valid;
            vld_b_reg        <= vld_a_reg;
            vld_c_reg        <= vld_b_reg;
            vld_d_reg        <= vld_c_reg;
            vld_e_reg        <= vld_d_reg;
            vld_reg          <= {vld_reg[NCELL-2:0], vld_e_reg};
            result_valid_reg <= vld_reg[NCELL-1];
        end
    end

`ifndef ASSERT_OFF
    a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.total_internal |-> result.reflectance == ONE_Q15)
        else $error("tir result not saturated");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.reflectance <= ONE_Q15)
        else $error("reflectance above one");

    a_tir_gt: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && side_reg[0].tir |-> side_reg[0].gt)
        else $error("tir flagged without n1 above n2");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
